FILE: src/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/atan_pkg.sv
package atan_pkg;

   localparam int Q_BITS     = 30;
   localparam int X_W        = 31;
   localparam int THR_W      = 10;
   localparam int MAG_W      = 30;
   localparam int P_W        = 30;
   localparam int A2_W       = 29;
   localparam int DIV_W      = 32;
   localparam int DIV_BITS   = 4;
   localparam int DIV_CYCLES = DIV_W / DIV_BITS;
   localparam int DCNT_W     = $clog2(DIV_CYCLES);

   localparam logic [MAG_W-1:0] HALF_Q = MAG_W'(1) << (Q_BITS - 1);

   // sequencer program counter, one value per microcode step
   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_SQUARE,
      STEP_DIV_INIT,
      STEP_DIV_RUN,
      STEP_TEST,
      STEP_ACCUM,
      STEP_DONE
   } step_type;

   // datapath operation of a step
   typedef enum logic [2:0] {
      OP_LOAD,
      OP_SQUARE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_HOLD,
      OP_ACCUM,
      OP_RESPOND
   } op_type;

   // jump condition: jump to target when true, else fall through
   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_START,
      COND_TERMS_DONE,
      COND_DIV_MORE,
      COND_BELOW_THR
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   // control store
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '{op: OP_HOLD, cond: COND_ALWAYS, target: STEP_IDLE};
      unique case (step)
         STEP_IDLE:     w = '{op: OP_LOAD,     cond: COND_NO_START,   target: STEP_IDLE};
         STEP_SQUARE:   w = '{op: OP_SQUARE,   cond: COND_NONE,       target: STEP_IDLE};
         STEP_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_TERMS_DONE, target: STEP_DONE};
         STEP_DIV_RUN:  w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE,   target: STEP_DIV_RUN};
         STEP_TEST:     w = '{op: OP_HOLD,     cond: COND_BELOW_THR,  target: STEP_DONE};
         STEP_ACCUM:    w = '{op: OP_ACCUM,    cond: COND_ALWAYS,     target: STEP_DIV_INIT};
         STEP_DONE:     w = '{op: OP_RESPOND,  cond: COND_ALWAYS,     target: STEP_IDLE};
         default:       w = '{op: OP_HOLD,     cond: COND_ALWAYS,     target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

FILE: src/arctan_power_series.sv
// from the accepted start the sequencer squares the argument; per term it initialises the
//   divider, divides, tests the quotient against the threshold and adds the term, stopping
//   at or below the threshold or at MAX_TERMS terms, then it responds
// one item at a time; the term divider resolves 4 quotient bits per cycle over a 32-bit dividend
// the receiver cannot stall: rsp_valid is a one-cycle beat, busy drops in that cycle
// reset (synchronous, active high) returns the sequencer to idle and clears the threshold
module arctan_power_series
   import atan_pkg::*;
#(
   parameter int MAX_TERMS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   // input beat
   input  logic                   start,
   output logic                   busy,
   input  logic signed [X_W-1:0]  req_x_value,
   // result beat
   output logic                   rsp_valid,
   output logic signed [X_W-1:0]  rsp_atan_value,
   output logic                   rsp_term_limit_hit,
   // threshold register
   input  logic                   csr_wr_en,
   input  logic [THR_W-1:0]       csr_wr_data
);

   // term counter holds 0..MAX_TERMS, odd index i = 2n+1 (n < MAX_TERMS) is sized for 2*MAX_TERMS-1
   localparam int N_W = $clog2(MAX_TERMS + 1);
   localparam int I_W = $clog2(2 * MAX_TERMS);
   localparam int R_W = I_W + 1;

   // sequencer
   step_type  pc_ff, pc_in;
   ucode_type uword;
   logic      cond_true;

   // configuration
   logic [THR_W-1:0] thr_ff;

   // operand and series state
   logic              neg_ff;
   logic [MAG_W-1:0]  a_ff;
   logic [A2_W-1:0]   a2_ff;
   logic [P_W-1:0]    p_ff;
   logic [N_W-1:0]    n_ff;
   logic signed [X_W-1:0] s_ff;
   logic              limit_ff;

   // divider
   logic [DIV_W-1:0]  quot_ff, quot_in;
   logic [R_W-1:0]    rem_ff, rem_in;
   logic [DCNT_W-1:0] dcnt_ff;

   // result register
   logic                   rsp_valid_ff;
   logic signed [X_W-1:0]  rsp_atan_ff;
   logic                   rsp_limit_ff;

   // combinational helpers
   logic [X_W-1:0]          x_mag;
   logic [MAG_W-1:0]        x_sat;
   logic [2*MAG_W-1:0]      sq_prod;
   logic [P_W+A2_W-1:0]     pw_prod;
   logic [I_W-1:0]          odd_idx;
   logic [R_W-1:0]          div_rem_v;
   logic [DIV_W-1:0]        div_q_v;
   logic                    div_ge;
   logic                    terms_done;
   logic                    div_more;
   logic                    below_thr;
   logic signed [X_W-1:0]   term_s;

   // ---------------------------------------------------------------
   // argument magnitude, saturated to one half
   // ---------------------------------------------------------------
   always_comb begin
      x_mag = req_x_value[X_W-1] ? (X_W'(0) - X_W'(req_x_value)) : X_W'(req_x_value);
      if (x_mag > X_W'(HALF_Q)) begin
         x_sat = HALF_Q;
      end else begin
         x_sat = x_mag[MAG_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // multipliers: a*a once per item, p*a2 once per term
   // ---------------------------------------------------------------
   assign sq_prod = {{MAG_W{1'b0}}, a_ff} * {{MAG_W{1'b0}}, a_ff};
   assign pw_prod = {{A2_W{1'b0}}, p_ff} * {{P_W{1'b0}}, a2_ff};

   // odd divisor 2n+1
   assign odd_idx = {n_ff[I_W-2:0], 1'b1};

   // ---------------------------------------------------------------
   // restoring divider, DIV_BITS quotient bits per cycle; remainder stays below i
   // ---------------------------------------------------------------
   always_comb begin
      div_rem_v = rem_ff;
      div_q_v   = quot_ff;
      div_ge    = 1'b0;
      for (int k = 0; k < DIV_BITS; k++) begin
         div_rem_v = {div_rem_v[R_W-2:0], div_q_v[DIV_W-1]};
         div_ge    = div_rem_v >= {1'b0, odd_idx};
         if (div_ge) begin
            div_rem_v = div_rem_v - {1'b0, odd_idx};
         end
         div_q_v = {div_q_v[DIV_W-2:0], div_ge};
      end
      rem_in  = div_rem_v;
      quot_in = div_q_v;
   end

   // ---------------------------------------------------------------
   // jump conditions
   // ---------------------------------------------------------------
   assign terms_done = n_ff == N_W'(MAX_TERMS);
   assign div_more   = dcnt_ff != DCNT_W'(DIV_CYCLES - 1);
   assign below_thr  = quot_ff <= {{(DIV_W-THR_W){1'b0}}, thr_ff};

   // ---------------------------------------------------------------
   // sequencer: fetch, then next step
   // ---------------------------------------------------------------
   assign uword = ucode_rom(pc_ff);

   always_comb begin
      case (uword.cond)
         COND_NONE:       cond_true = 1'b0;
         COND_ALWAYS:     cond_true = 1'b1;
         COND_NO_START:   cond_true = !start;
         COND_TERMS_DONE: cond_true = terms_done;
         COND_DIV_MORE:   cond_true = div_more;
         COND_BELOW_THR:  cond_true = below_thr;
         default:         cond_true = 1'b1;
      endcase
   end

   always_comb begin
      if (cond_true) begin
         pc_in = uword.target;
      end else begin
         pc_in = step_type'(pc_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign busy = pc_ff != STEP_IDLE;

   // ---------------------------------------------------------------
   // threshold register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------
   // datapath, driven by the control word
   // ---------------------------------------------------------------
   // added term: sign + when i mod 4 == 1, i.e. n even
   assign term_s = n_ff[0] ? (s_ff - X_W'(quot_ff[X_W-1:0]))
                           : (s_ff + X_W'(quot_ff[X_W-1:0]));

   always_ff @(posedge clock) begin
      unique case (uword.op)
         OP_LOAD: begin
            if (start) begin
               neg_ff <= req_x_value[X_W-1];
               a_ff   <= x_sat;
            end
         end
         OP_SQUARE: begin
            a2_ff    <= sq_prod[Q_BITS+A2_W-1:Q_BITS];
            p_ff     <= a_ff;
            n_ff     <= '0;
            s_ff     <= '0;
            limit_ff <= 1'b0;
         end
         OP_DIV_INIT: begin
            quot_ff  <= {{(DIV_W-P_W){1'b0}}, p_ff};
            rem_ff   <= '0;
            dcnt_ff  <= '0;
            limit_ff <= terms_done;
         end
         OP_DIV_STEP: begin
            quot_ff <= quot_in;
            rem_ff  <= rem_in;
            dcnt_ff <= dcnt_ff + DCNT_W'(1);
         end
         OP_ACCUM: begin
            s_ff <= term_s;
            // a2 is below 2^29, so the shifted power fits in one bit less than p
            p_ff <= {1'b0, pw_prod[P_W+A2_W-1:Q_BITS]};
            n_ff <= n_ff + N_W'(1);
         end
         OP_RESPOND: begin
            rsp_atan_ff  <= neg_ff ? (X_W'(0) - s_ff) : s_ff;
            rsp_limit_ff <= limit_ff;
         end
         OP_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   // result strobe, one beat per item
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= uword.op == OP_RESPOND;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_atan_value     = rsp_atan_ff;
   assign rsp_term_limit_hit = rsp_limit_ff;

endmodule

FILE: src/atan_checker.sv
`include "assert_macros.svh"

module atan_checker
   import atan_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic signed [X_W-1:0] rsp_atan_value,
   input logic                  rsp_valid,
   input logic                  rsp_term_limit_hit
);

   localparam logic signed [X_W-1:0] MAX_OUT = X_W'(HALF_Q);

   logic rsp_in_range;

   assign rsp_in_range = (rsp_atan_value <= MAX_OUT) && (rsp_atan_value >= -MAX_OUT);

   // an accepted beat starts work
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   // result strobe is a single-cycle pulse
   `ASSERT_NEXT(a_rsp_pulse, clock, reset, rsp_valid, !rsp_valid)
   // a result only follows a busy period
   `ASSERT_SAME(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   // arctangent of an argument within one half stays within one half
   `ASSERT_SAME(a_rsp_range, clock, reset, rsp_valid, rsp_in_range)
   // term_limit_hit is known whenever a result is shown
   `ASSERT_ALWAYS(a_flag_known, clock, reset, !rsp_valid || !$isunknown(rsp_term_limit_hit))

endmodule

bind arctan_power_series atan_checker u_atan_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_atan_value     (rsp_atan_value),
   .rsp_valid          (rsp_valid),
   .rsp_term_limit_hit (rsp_term_limit_hit)
);
